### rtl/dda_pkg.sv
// dda_pkg: shared types and constants of the dda stepper axis
// no dependencies; used by the step logic, the top level and the checker

package dda_pkg;

  localparam int REG_W       = 32;
  localparam int DENOM_W     = 31;
  localparam int KIND_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 8;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - REG_W - 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK   = 2'd0,
    KIND_START  = 2'd1,
    KIND_SETPOS = 2'd2
  } dda_kind_t;

  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MAX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DENOM    = 2'd2;

  typedef struct packed {
    logic stepped;
    logic moving_reverse;
    logic reached;
  } dda_flags_t;

endpackage

### rtl/dda_stepper_axis.sv
// dda_stepper_axis: one axis of a Bresenham-style multi-axis move
// depends on dda_pkg and dda_step

// Takes one word per clock while in_tready is high and returns one result word
// per input word. Tick, start-move and set-position words are all handled
// by the combinational step logic, which updates position, direction, delta
// and the DDA accumulator in place. Results go through an output register backed
// by a one-word skid register, so in_tready drops only when both hold words that
// the sink has not taken. Configuration writes are accepted in every cycle and
// take effect on the next input word; they are meant to happen while the axis is
// idle. Internal arithmetic and compares are POSITION_WIDTH bits wide, signed.

module dda_stepper_axis import dda_pkg::*; #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // position_value[31:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // kind[1:0], zeros above
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // stepped, moving_reverse,
                                             // position_now[31:0], reached, zeros
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [REG_W-1:0]       cfg_data
);

  localparam int PW = POSITION_WIDTH;

  logic signed [PW-1:0] axis_max_r;
  logic signed [PW-1:0] target_r;
  logic signed [PW-1:0] denom_r;
  logic signed [PW-1:0] pos_r;
  logic signed [PW-1:0] acc_r;
  logic signed [PW-1:0] delta_r;
  logic                 rev_r;

  logic signed [PW-1:0] pos_nxt;
  logic signed [PW-1:0] acc_nxt;
  logic signed [PW-1:0] delta_nxt;
  logic                 rev_nxt;
  dda_flags_t           flags;

  logic signed [REG_W-1:0] cfg_data_s;
  logic signed [REG_W-1:0] in_pos_s;
  logic signed [PW-1:0]    in_pos;
  logic signed [REG_W-1:0] pos_out;

  logic                   in_fire;
  logic                   out_pop;
  logic [OUT_TDATA_W-1:0] res_word;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TDATA_W-1:0] out_data_nxt;
  logic                   skid_valid_r;
  logic                   skid_valid_nxt;
  logic [OUT_TDATA_W-1:0] skid_data_r;
  logic [OUT_TDATA_W-1:0] skid_data_nxt;

  assign cfg_ready  = 1'b1;
  assign cfg_data_s = cfg_data;
  assign in_pos_s   = in_tdata[REG_W-1:0];
  assign in_pos     = PW'(in_pos_s);

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_pop   = out_valid_r && out_tready;

  dda_step #(
    .PW (PW)
  ) u_step (
    .kind      (in_tuser[KIND_W-1:0]),
    .pos_value (in_pos),
    .pos       (pos_r),
    .acc       (acc_r),
    .delta     (delta_r),
    .rev       (rev_r),
    .axis_max  (axis_max_r),
    .target    (target_r),
    .denom     (denom_r),
    .pos_nxt   (pos_nxt),
    .acc_nxt   (acc_nxt),
    .delta_nxt (delta_nxt),
    .rev_nxt   (rev_nxt),
    .flags     (flags)
  );

  // low 32 bits of the new position, sign kept for narrow widths
  assign pos_out  = REG_W'(pos_nxt);
  assign res_word = {{OUT_PAD_W{1'b0}}, flags.reached, pos_out,
                     flags.moving_reverse, flags.stepped};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_max_r <= '0;
      target_r   <= '0;
      denom_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_AXIS_MAX: axis_max_r <= PW'(cfg_data_s);
        CFG_TARGET:   target_r   <= PW'(cfg_data_s);
        CFG_DENOM:    denom_r    <= PW'(cfg_data[DENOM_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      acc_r   <= '0;
      delta_r <= '0;
      rev_r   <= 1'b0;
    end else if (in_fire) begin
      pos_r   <= pos_nxt;
      acc_r   <= acc_nxt;
      delta_r <= delta_nxt;
      rev_r   <= rev_nxt;
    end
  end

  // output register with one skid word behind it
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_pop) begin
      out_valid_nxt  = skid_valid_r || in_fire;
      out_data_nxt   = skid_valid_r ? skid_data_r : res_word;
      skid_valid_nxt = 1'b0;
    end else if (in_fire) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/dda_step.sv
// dda_step: next-state and result logic for one item of the stepper axis
// depends on dda_pkg

module dda_step import dda_pkg::*; #(
  parameter int PW = 32
) (
  input  logic [KIND_W-1:0]   kind,
  input  logic signed [PW-1:0] pos_value,
  input  logic signed [PW-1:0] pos,
  input  logic signed [PW-1:0] acc,
  input  logic signed [PW-1:0] delta,
  input  logic                 rev,
  input  logic signed [PW-1:0] axis_max,
  input  logic signed [PW-1:0] target,
  input  logic signed [PW-1:0] denom,
  output logic signed [PW-1:0] pos_nxt,
  output logic signed [PW-1:0] acc_nxt,
  output logic signed [PW-1:0] delta_nxt,
  output logic                 rev_nxt,
  output dda_flags_t           flags
);

  localparam logic signed [PW-1:0] ONE = PW'(1);

  function automatic logic at_goal(input logic signed [PW-1:0] p,
                                   input logic                 r,
                                   input logic signed [PW-1:0] tgt,
                                   input logic signed [PW-1:0] amax);
    logic res;
    if (!r) begin
      res = (p >= tgt) || (p >= amax);
    end else begin
      res = (tgt >= p) || p[PW-1] || (p == '0);
    end
    return res;
  endfunction

  logic signed [PW-1:0] aim_base;
  logic signed [PW-1:0] diff;
  logic signed [PW-1:0] aim_delta;
  logic                 aim_rev;
  logic signed [PW-1:0] acc_sum;
  logic                 fire;
  logic                 blocked;
  logic                 step;

  // aim uses the new position on a set-position word
  assign aim_base  = (dda_kind_t'(kind) == KIND_SETPOS) ? pos_value : pos;
  assign diff      = target - aim_base;
  assign aim_rev   = target < aim_base;
  assign aim_delta = diff[PW-1] ? -diff : diff;

  assign acc_sum = acc + delta;
  assign fire    = !acc_sum[PW-1] && (acc_sum != '0);
  assign blocked = at_goal(pos, rev, target, axis_max);

  always_comb begin
    pos_nxt   = pos;
    acc_nxt   = acc;
    delta_nxt = delta;
    rev_nxt   = rev;
    step      = 1'b0;
    case (dda_kind_t'(kind))
      KIND_TICK: begin
        step    = fire && !blocked;
        acc_nxt = fire ? (acc_sum - denom) : acc_sum;
        if (step) begin
          pos_nxt = rev ? (pos - ONE) : (pos + ONE);
        end
      end
      KIND_START: begin
        rev_nxt   = aim_rev;
        delta_nxt = aim_delta;
        acc_nxt   = -(denom >>> 1);
      end
      KIND_SETPOS: begin
        pos_nxt   = pos_value;
        rev_nxt   = aim_rev;
        delta_nxt = aim_delta;
      end
      default: begin
        step = 1'b0;
      end
    endcase
  end

  assign flags.stepped        = step;
  assign flags.moving_reverse = rev_nxt;
  assign flags.reached        = at_goal(pos_nxt, rev_nxt, target, axis_max);

endmodule

### rtl/dda_axis_chk.sv
// dda_axis_chk: port-level checks of dda_stepper_axis, bound to the top level
// depends on dda_pkg

module dda_axis_chk import dda_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // reset empties the output side and opens the input
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("output not empty after reset");

  // input is only held off while a result waits
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  // an accepted word always shows up on the next cycle when room exists
  a_one_cycle_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (!out_tvalid || out_tready)) |=> out_tvalid)
    else $error("accepted word produced no result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed or dropped");

endmodule

bind dda_stepper_axis dda_axis_chk u_dda_axis_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
